// ----- hdl/sass_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite animation slot sequencer package
// Shared types and codes for the slot sequencer controller, datapath and top.
// ----------------------------------------------------------------------------
package sass_pkg;

   localparam int SLOT_W  = 4;
   localparam int FRAME_W = 8;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_STEP    = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   localparam logic [1:0] HEAD_FWD  = 2'b01;
   localparam logic [1:0] HEAD_BACK = 2'b11;

   typedef struct packed {
      logic               capture;
      logic               search_next;
      logic               alloc_load;
      logic               alloc_reject;
      logic               tick_run;
      logic               release_slot;
      logic               report;
   } cmd_type;

   typedef struct packed {
      logic               pool_full;
      logic               ptr_free;
   } status_type;

   typedef struct packed {
      logic [FRAME_W-1:0] prescale;
      logic [FRAME_W-1:0] rate;
      logic               bounce;
      logic [FRAME_W-1:0] restart_frame;
      logic [FRAME_W-1:0] end_frame;
      logic [FRAME_W-1:0] cur_frame;
      logic [1:0]         heading;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

endpackage

// ----- hdl/sprite_animation_slot_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Sprite animation slot sequencer core
// Pool of animation slots: allocate, release and tick one slot per word.
//
//   channel  | ports            | handshake                   | words
//   ---------+------------------+-----------------------------+---------------
//   request  | req_*            | start high while busy low   | one per op
//   response | rsp_*            | rsp_strobe, one cycle       | one per request
//
// After accept, release and no-op each pass through their own working state, step
// passes through fetch and tick, and allocate searches round-robin, skipping
// occupied slots (at most SLOTS - 1). The search steps one slot per cycle.
// The response appears the cycle after the last working cycle, as busy drops.
// Reset clears occupancy, pointer, count and slot valid bits; no sweep.
// The receiver cannot stall: each response word is shown for one cycle only.
// ----------------------------------------------------------------------------
module sprite_animation_slot_sequencer_core
   import sass_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_slot,
   input  logic [7:0]         req_frame_count,
   input  logic [7:0]         req_start_frame,
   input  logic [7:0]         req_loop_frame,
   input  logic [7:0]         req_tick_speed,
   input  logic signed [1:0]  req_step_dir,
   input  logic               req_ping_pong,
   output logic               rsp_strobe,
   output logic [3:0]         rsp_slot_out,
   output logic               rsp_accepted,
   output logic [7:0]         rsp_frame,
   output logic               rsp_waiting,
   output logic [4:0]         rsp_active_count
);

   cmd_type    cmd;
   status_type status;

   sass_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sass_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_slot         (req_slot),
      .req_frame_count  (req_frame_count),
      .req_start_frame  (req_start_frame),
      .req_loop_frame   (req_loop_frame),
      .req_tick_speed   (req_tick_speed),
      .req_step_dir     (req_step_dir),
      .req_ping_pong    (req_ping_pong),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_accepted     (rsp_accepted),
      .rsp_frame        (rsp_frame),
      .rsp_waiting      (rsp_waiting),
      .rsp_active_count (rsp_active_count)
   );

endmodule

// ----- hdl/sass_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sass_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sass_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot sequencer controller
// Sequences accept, round-robin search, record fetch, tick, release and report per word.
// ----------------------------------------------------------------------------
module sass_ctrl
   import sass_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_op,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SEARCH  = 6'b000010,
      ST_FETCH   = 6'b000100,
      ST_TICK    = 6'b001000,
      ST_RELEASE = 6'b010000,
      ST_REPORT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               unique case (op_type'(req_op))
                  OP_ALLOC:   state_in = ST_SEARCH;
                  OP_RELEASE: state_in = ST_RELEASE;
                  OP_STEP:    state_in = ST_FETCH;
                  OP_NOP:     state_in = ST_REPORT;
                  default:    state_in = ST_REPORT;
               endcase
            end
         end
         ST_SEARCH: begin
            if (status.pool_full) begin
               cmd.alloc_reject = 1'b1;
               state_in         = ST_IDLE;
            end else if (status.ptr_free) begin
               cmd.alloc_load = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.search_next = 1'b1;
            end
         end
         ST_FETCH: begin
            state_in = ST_TICK;
         end
         ST_TICK: begin
            cmd.tick_run = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RELEASE: begin
            cmd.release_slot = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- hdl/sass_dp.sv -----
// ----------------------------------------------------------------------------
// Slot sequencer datapath
// Slot occupancy, search pointer, slot record store, tick unit and result.
// ----------------------------------------------------------------------------
module sass_dp
   import sass_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [FRAME_W-1:0] req_frame_count,
   input  logic [FRAME_W-1:0] req_start_frame,
   input  logic [FRAME_W-1:0] req_loop_frame,
   input  logic [FRAME_W-1:0] req_tick_speed,
   input  logic [1:0]         req_step_dir,
   input  logic               req_ping_pong,
   output logic               rsp_strobe,
   output logic [SLOT_W-1:0]  rsp_slot_out,
   output logic               rsp_accepted,
   output logic [FRAME_W-1:0] rsp_frame,
   output logic               rsp_waiting,
   output logic [COUNT_W-1:0] rsp_active_count
);

   localparam int SW    = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (SW > SLOT_W) ? SW + 1 : SLOT_W + 1;

   logic [SLOT_W-1:0]  slot_ff;
   logic [FRAME_W-1:0] frame_count_ff;
   logic [FRAME_W-1:0] start_frame_ff;
   logic [FRAME_W-1:0] loop_frame_ff;
   logic [FRAME_W-1:0] tick_speed_ff;
   logic [1:0]         step_dir_ff;
   logic               ping_pong_ff;

   logic [SLOTS-1:0]   in_use_ff;
   logic [SLOTS-1:0]   written_ff;
   logic [SW-1:0]      ptr_ff;
   logic [CNT_W-1:0]   busy_count_ff;
   logic               entry_valid_ff;

   logic               rsp_strobe_ff;
   logic [SLOT_W-1:0]  rsp_slot_out_ff;
   logic               rsp_accepted_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic               rsp_waiting_ff;

   logic [SW-1:0]      slot_idx;
   logic               in_range;
   logic               do_release;
   rec_type            rd_rec;
   rec_type            cur_rec;
   rec_type            tick_rec;
   rec_type            alloc_rec;
   logic               ram_we;
   logic [SW-1:0]      ram_waddr;
   rec_type            ram_wdata;

   assign slot_idx   = SW'(slot_ff);
   assign in_range   = (CMP_W'(slot_ff) < CMP_W'(SLOTS));
   assign do_release = cmd.release_slot && in_range && in_use_ff[slot_idx];

   assign status.pool_full = (busy_count_ff == CNT_W'(SLOTS));
   assign status.ptr_free  = !in_use_ff[ptr_ff];

   sass_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (slot_idx),
      .rd_data (rd_rec)
   );

   always_comb begin
      alloc_rec               = '0;
      alloc_rec.rate          = tick_speed_ff;
      alloc_rec.bounce        = ping_pong_ff;
      alloc_rec.restart_frame = loop_frame_ff;
      alloc_rec.end_frame     = frame_count_ff;
      alloc_rec.cur_frame     = start_frame_ff;
      alloc_rec.heading       = step_dir_ff;
   end

   // one tick on the fetched record; never written entries read as zero
   always_comb begin
      cur_rec  = entry_valid_ff ? rd_rec : '0;
      tick_rec = cur_rec;
      if (cur_rec.prescale == '0) begin
         tick_rec.prescale  = cur_rec.rate;
         tick_rec.cur_frame = cur_rec.cur_frame
                            + {{(FRAME_W-2){cur_rec.heading[1]}}, cur_rec.heading};
         if (cur_rec.heading == HEAD_FWD && tick_rec.cur_frame >= cur_rec.end_frame) begin
            if (cur_rec.bounce) begin
               tick_rec.heading = HEAD_BACK;
            end else begin
               tick_rec.cur_frame = cur_rec.restart_frame;
            end
         end
         if (tick_rec.heading[1] && tick_rec.cur_frame <= cur_rec.restart_frame) begin
            tick_rec.heading = HEAD_FWD;
         end
      end
      if (cur_rec.rate != '0) begin
         tick_rec.prescale = tick_rec.prescale - 1'b1;
      end
   end

   assign ram_we    = cmd.alloc_load || (cmd.tick_run && in_range);
   assign ram_waddr = cmd.alloc_load ? ptr_ff : slot_idx;
   assign ram_wdata = cmd.alloc_load ? alloc_rec : tick_rec;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff        <= req_slot;
         frame_count_ff <= req_frame_count;
         start_frame_ff <= req_start_frame;
         loop_frame_ff  <= req_loop_frame;
         tick_speed_ff  <= req_tick_speed;
         step_dir_ff    <= req_step_dir;
         ping_pong_ff   <= req_ping_pong;
      end
      entry_valid_ff <= written_ff[slot_idx];

      rsp_slot_out_ff <= (cmd.tick_run || cmd.release_slot) ? slot_ff : SLOT_W'(ptr_ff);
      rsp_accepted_ff <= cmd.alloc_load;
      rsp_frame_ff    <= (cmd.tick_run && in_range) ? tick_rec.cur_frame : '0;
      rsp_waiting_ff  <= cmd.tick_run && in_range && (tick_rec.prescale != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff     <= '0;
         written_ff    <= '0;
         ptr_ff        <= '0;
         busy_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.alloc_load || cmd.alloc_reject || cmd.tick_run
                        || cmd.release_slot || cmd.report;
         if (cmd.search_next) begin
            ptr_ff <= (ptr_ff == SW'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
         end
         if (cmd.alloc_load) begin
            in_use_ff[ptr_ff]  <= 1'b1;
            written_ff[ptr_ff] <= 1'b1;
            busy_count_ff      <= busy_count_ff + 1'b1;
         end
         if (cmd.tick_run && in_range) begin
            written_ff[slot_idx] <= 1'b1;
         end
         if (do_release) begin
            in_use_ff[slot_idx] <= 1'b0;
            busy_count_ff       <= busy_count_ff - 1'b1;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_slot_out     = rsp_slot_out_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_waiting      = rsp_waiting_ff;
   assign rsp_active_count = COUNT_W'(busy_count_ff);

endmodule

// ----- sim/sprite_animation_slot_sequencer_core_check.sv -----
// ----------------------------------------------------------------------------
// Slot sequencer response checker
// Watches the request and response channels of the slot sequencer core.
// It keeps its own copy of the slot pool and works out the response word
// for each accepted request. Each response word is compared field by field
// with the oldest outstanding word, and mismatches are counted.
// ----------------------------------------------------------------------------
module sprite_animation_slot_sequencer_core_check
   import sass_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_op,
   input  logic [3:0]        req_slot,
   input  logic [7:0]        req_frame_count,
   input  logic [7:0]        req_start_frame,
   input  logic [7:0]        req_loop_frame,
   input  logic [7:0]        req_tick_speed,
   input  logic signed [1:0] req_step_dir,
   input  logic              req_ping_pong,
   input  logic              rsp_strobe,
   input  logic [3:0]        rsp_slot_out,
   input  logic              rsp_accepted,
   input  logic [7:0]        rsp_frame,
   input  logic              rsp_waiting,
   input  logic [4:0]        rsp_active_count,
   output int                mismatch_count,
   output int                outstanding
);

   typedef struct packed {
      logic [3:0] slot_out;
      logic       accepted;
      logic [7:0] frame;
      logic       waiting;
      logic [4:0] active_count;
   } anim_word_t;

   logic       in_use        [SLOTS];
   logic       bounce        [SLOTS];
   logic [7:0] prescale      [SLOTS];
   logic [7:0] rate          [SLOTS];
   logic [7:0] restart_frame [SLOTS];
   logic [7:0] end_frame     [SLOTS];
   logic [7:0] cur_frame     [SLOTS];
   logic [1:0] heading       [SLOTS];
   logic [7:0] shown_frame   [SLOTS];
   logic [3:0] search_ptr;
   logic [4:0] busy_count;

   anim_word_t due_words [$];
   int         errs;

   function automatic void clear_pool();
      for (int i = 0; i < SLOTS; i++) begin
         in_use[i]        = 1'b0;
         bounce[i]        = 1'b0;
         prescale[i]      = '0;
         rate[i]          = '0;
         restart_frame[i] = '0;
         end_frame[i]     = '0;
         cur_frame[i]     = '0;
         heading[i]       = '0;
         shown_frame[i]   = '0;
      end
      search_ptr = '0;
      busy_count = '0;
   endfunction

   function automatic void tick_slot(input int s);
      if (prescale[s] == 8'd0) begin
         prescale[s]  = rate[s];
         cur_frame[s] = cur_frame[s] + {{6{heading[s][1]}}, heading[s]};
         if (heading[s] == HEAD_FWD && cur_frame[s] >= end_frame[s]) begin
            if (bounce[s])
               heading[s] = HEAD_BACK;
            else
               cur_frame[s] = restart_frame[s];
         end
         if (heading[s][1] && cur_frame[s] <= restart_frame[s])
            heading[s] = HEAD_FWD;
      end
      if (rate[s] != 8'd0)
         prescale[s] = prescale[s] - 8'd1;
      shown_frame[s] = cur_frame[s];
   endfunction

   function automatic anim_word_t apply_word();
      anim_word_t w;
      int         s;
      w          = '0;
      w.slot_out = search_ptr;
      case (op_type'(req_op))
         OP_ALLOC: begin
            if (busy_count < SLOTS) begin
               for (int n = 0; n < SLOTS && in_use[search_ptr]; n++)
                  search_ptr = 4'((int'(search_ptr) + 1) % SLOTS);
               if (!in_use[search_ptr]) begin
                  s                = search_ptr;
                  in_use[s]        = 1'b1;
                  prescale[s]      = '0;
                  rate[s]          = req_tick_speed;
                  bounce[s]        = req_ping_pong;
                  restart_frame[s] = req_loop_frame;
                  end_frame[s]     = req_frame_count;
                  cur_frame[s]     = req_start_frame;
                  heading[s]       = req_step_dir;
                  shown_frame[s]   = '0;
                  busy_count       = busy_count + 5'd1;
                  w.accepted       = 1'b1;
               end
            end
            w.slot_out = search_ptr;
         end
         OP_RELEASE: begin
            w.slot_out = req_slot;
            if (req_slot < SLOTS && in_use[req_slot]) begin
               in_use[req_slot] = 1'b0;
               busy_count       = busy_count - 5'd1;
            end
         end
         OP_STEP: begin
            w.slot_out = req_slot;
            if (req_slot < SLOTS) begin
               tick_slot(req_slot);
               w.frame   = shown_frame[req_slot];
               w.waiting = prescale[req_slot] != 8'd0;
            end
         end
         default: ;
      endcase
      w.active_count = busy_count;
      return w;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
         errs++;
      end
   endfunction

   initial begin
      errs = 0;
      clear_pool();
   end

   always @(posedge clock) begin
      anim_word_t want;
      if (reset) begin
         clear_pool();
         due_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (due_words.size() == 0) begin
               $display("%0t unexpected word: expected none, actual slot %0h count %0h",
                        $time, rsp_slot_out, rsp_active_count);
               errs++;
            end else begin
               want = due_words.pop_front();
               compare_field("slot_out", 8'(want.slot_out), 8'(rsp_slot_out));
               compare_field("accepted", 8'(want.accepted), 8'(rsp_accepted));
               compare_field("frame", want.frame, rsp_frame);
               compare_field("waiting", 8'(want.waiting), 8'(rsp_waiting));
               compare_field("active_count", 8'(want.active_count),
                             8'(rsp_active_count));
            end
         end
         if (start && !busy)
            due_words.push_back(apply_word());
      end
      mismatch_count <= errs;
      outstanding    <= due_words.size();
   end

endmodule

// ----- sim/sprite_animation_slot_sequencer_core_tb.sv -----
// ----------------------------------------------------------------------------
// Slot sequencer core testbench
// Drives directed and random allocate, release, step and no-op words into the
// slot sequencer core with random gaps, while a checker beside the core
// predicts and compares every response word. A watchdog ends a stalled run.
// ----------------------------------------------------------------------------
module sprite_animation_slot_sequencer_core_tb;
   import sass_pkg::*;

   localparam int SLOTS      = 16;
   localparam int STALL_MAX  = 500;
   localparam int PHASE_LEN  = 240;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_op = OP_NOP;
   logic [3:0]        req_slot = '0;
   logic [7:0]        req_frame_count = '0;
   logic [7:0]        req_start_frame = '0;
   logic [7:0]        req_loop_frame = '0;
   logic [7:0]        req_tick_speed = '0;
   logic signed [1:0] req_step_dir = '0;
   logic              req_ping_pong = 1'b0;
   logic              rsp_strobe;
   logic [3:0]        rsp_slot_out;
   logic              rsp_accepted;
   logic [7:0]        rsp_frame;
   logic              rsp_waiting;
   logic [4:0]        rsp_active_count;
   int                mismatch_count;
   int                outstanding;
   int                stall_cycles = 0;
   bit                gaps_on = 1'b1;

   always #5 clock = ~clock;

   sprite_animation_slot_sequencer_core #(.SLOTS(SLOTS)) DUT (.*);

   sprite_animation_slot_sequencer_core_check #(.SLOTS(SLOTS)) u_check (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("[sprite_animation_slot_sequencer_core] ERROR");
         $finish;
      end
   end

   task automatic send_word(input op_type op, input logic [3:0] slot,
                            input logic [7:0] fcount, input logic [7:0] sframe,
                            input logic [7:0] lframe, input logic [7:0] speed,
                            input logic [1:0] dir, input logic pp);
      int gap;
      req_op          <= op;
      req_slot        <= slot;
      req_frame_count <= fcount;
      req_start_frame <= sframe;
      req_loop_frame  <= lframe;
      req_tick_speed  <= speed;
      req_step_dir    <= dir;
      req_ping_pong   <= pp;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (gaps_on && $urandom_range(0, 99) < 38) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_frame();
      if ($urandom_range(0, 1))
         return 8'($urandom_range(0, 12));
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_speed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 8'd0;
      if (r < 90)
         return 8'($urandom_range(1, 3));
      return 8'($urandom);
   endfunction

   function automatic logic [1:0] pick_dir();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return HEAD_FWD;
      if (r < 70)
         return HEAD_BACK;
      if (r < 85)
         return 2'b00;
      return 2'b10;
   endfunction

   task automatic send_random(input int phase);
      int     r;
      op_type op;
      r = $urandom_range(0, 99);
      case (phase)
         0: op = (r < 45) ? OP_ALLOC : (r < 55) ? OP_RELEASE : (r < 95) ? OP_STEP : OP_NOP;
         1: op = (r < 20) ? OP_ALLOC : (r < 30) ? OP_RELEASE : (r < 95) ? OP_STEP : OP_NOP;
         2: op = (r < 15) ? OP_ALLOC : (r < 50) ? OP_RELEASE : (r < 95) ? OP_STEP : OP_NOP;
         default: op = (r < 30) ? OP_ALLOC : (r < 55) ? OP_RELEASE : (r < 95) ? OP_STEP : OP_NOP;
      endcase
      send_word(op, 4'($urandom), pick_frame(), pick_frame(), pick_frame(), pick_speed(),
                pick_dir(), 1'($urandom));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_STEP, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_NOP, 4'hf, 8'hff, 8'hff, 8'hff, 8'hff, 2'b11, 1'b1);
      send_word(OP_RELEASE, 4'd3, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd255, 8'd255, 8'd0, 8'd0, HEAD_FWD, 1'b0);
      send_word(OP_STEP, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_STEP, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd3, 8'd2, 8'd0, 8'd0, HEAD_FWD, 1'b0);
      send_word(OP_STEP, 4'd1, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd2, 8'd1, 8'd5, 8'd0, HEAD_FWD, 1'b1);
      send_word(OP_STEP, 4'd2, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd5, 8'd4, 8'd2, 8'd0, HEAD_FWD, 1'b1);
      repeat (4) send_word(OP_STEP, 4'd3, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd0, 8'd0, 8'd255, 8'd255, HEAD_BACK, 1'b1);
      repeat (2) send_word(OP_STEP, 4'd4, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd10, 8'd8, 8'd1, 8'd1, 2'b10, 1'b0);
      repeat (3) send_word(OP_STEP, 4'd5, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd7, 8'd7, 8'd7, 8'd0, 2'b00, 1'b0);
      send_word(OP_STEP, 4'd6, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      repeat (2) send_word(OP_RELEASE, 4'd6, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      repeat (11) send_word(OP_ALLOC, 4'($urandom), pick_frame(), pick_frame(), pick_frame(),
                            pick_speed(), pick_dir(), 1'($urandom));
      send_word(OP_RELEASE, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'b00, 1'b0);
      send_word(OP_ALLOC, 4'd0, 8'd4, 8'd0, 8'd0, 8'd0, HEAD_FWD, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < PHASE_LEN; i++) begin
            gaps_on = !(phase == 1 && i < 150);
            send_random(phase);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("[sprite_animation_slot_sequencer_core] OK");
      else
         $display("[sprite_animation_slot_sequencer_core] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/sass_pkg.sv
hdl/sass_ram.sv
hdl/sass_ctrl.sv
hdl/sass_dp.sv
hdl/sprite_animation_slot_sequencer_core.sv
sim/sprite_animation_slot_sequencer_core_check.sv
sim/sprite_animation_slot_sequencer_core_tb.sv
